>>> rtl/ppmt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths of the priority policy match table.
package ppmt_pkg;

  localparam int unsigned TableDepthDefault = 1024;

  localparam int unsigned OpW      = 2;
  localparam int unsigned DataW    = 32;
  localparam int unsigned WideW    = 64;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned RuleIdxW = 10;

  localparam logic [OpW-1:0] OP_INSERT    = 2'd0;
  localparam logic [OpW-1:0] OP_DECIDE    = 2'd1;
  localparam logic [OpW-1:0] OP_RECOMMEND = 2'd2;

  localparam logic [StatusW-1:0] ST_INSERTED   = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL       = 3'd1;
  localparam logic [StatusW-1:0] ST_NO_MATCH   = 3'd2;
  localparam logic [StatusW-1:0] ST_APPLIED    = 3'd3;
  localparam logic [StatusW-1:0] ST_BAD_ACTION = 3'd4;

  localparam logic [DataW-1:0] ACT_KIND_LOW  = 32'd1;
  localparam logic [DataW-1:0] ACT_KIND_HIGH = 32'd5;

  typedef struct packed {
    logic [DataW-1:0] kind;
    logic [DataW-1:0] threshold;
    logic [DataW-1:0] act_kind;
    logic [DataW-1:0] act_value;
    logic [DataW-1:0] prio;
  } rule_t;

  // An action kind inside the supported range counts as applied.
  function automatic logic action_ok(logic [DataW-1:0] ak);
    return ak inside {[ACT_KIND_LOW:ACT_KIND_HIGH]};
  endfunction

endpackage

>>> rtl/priority_policy_match_table.sv
`timescale 1ns / 1ps
// Top level of the priority policy match table: control, scan and counters.
//
// Usage: an item is taken at a rising edge where start is high and busy is
// low. Opcode insert appends a rule, decide looks for the best rule whose kind
// matches and whose threshold is at most the observed value, recommend looks
// for the best rule by kind alone. Opcode 3 is dropped without a result.
// Each item that gives a result raises result_valid_o for exactly one cycle
// with all result fields; the receiver cannot hold results off, so the block
// never waits on the output side.
// Order and rate: an insert gives its result in the cycle after it is taken.
// Decide and recommend read the installed rules out of the rule memory one per
// cycle through its registered read port and compare each rule as it arrives;
// a decide that finds a winner then also reads and writes back the hit count
// of that rule before its result is shown. busy is high while a scan or that
// hit count update runs, and a new item may be taken in the same cycle that a
// result is shown.
// Reset clears the rule count and the decision counters; the memories hold no
// reset values and need no clearing pass, since only written rules are read.
module priority_policy_match_table import ppmt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [DataW-1:0]    rule_kind_i,
  input  logic [DataW-1:0]    rule_threshold_i,
  input  logic [DataW-1:0]    observed_value_i,
  input  logic [DataW-1:0]    new_action_kind_i,
  input  logic [DataW-1:0]    new_action_value_i,
  input  logic [DataW-1:0]    new_priority_i,
  input  logic [WideW-1:0]    current_setting_i,
  output logic                result_valid_o,
  output logic [StatusW-1:0]  status_o,
  output logic [RuleIdxW-1:0] rule_index_o,
  output logic [DataW-1:0]    chosen_action_kind_o,
  output logic [DataW-1:0]    chosen_action_value_o,
  output logic [WideW-1:0]    recommendation_o,
  output logic [DataW-1:0]    rule_hits_o,
  output logic [DataW-1:0]    decisions_total_o,
  output logic [DataW-1:0]    applied_total_o,
  output logic [DataW-1:0]    failed_total_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HIT  = 2'd2;

  // Control state.
  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic             found_q, found_d;
  logic             valid_q, valid_d;
  logic [DataW-1:0] decisions_q, decisions_d;
  logic [DataW-1:0] applied_q, applied_d;
  logic [DataW-1:0] failed_q, failed_d;

  // Item fields and best-so-far tracking.
  logic             decide_q, decide_d;
  logic [DataW-1:0] kind_q, kind_d;
  logic [DataW-1:0] obs_q, obs_d;
  logic [WideW-1:0] cur_q, cur_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [DataW-1:0] best_pri_q, best_pri_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [DataW-1:0] best_ak_q, best_ak_d;
  logic [DataW-1:0] best_av_q, best_av_d;

  // Result registers.
  logic [StatusW-1:0]  status_q, status_d;
  logic [RuleIdxW-1:0] ridx_q, ridx_d;
  logic [DataW-1:0]    ak_q, ak_d;
  logic [DataW-1:0]    av_q, av_d;
  logic [WideW-1:0]    rec_q, rec_d;
  logic [DataW-1:0]    hits_q, hits_d;

  // Memory controls.
  logic             rule_we, rule_re;
  rule_t            rule_wdata, rule_rdata;
  logic             hit_clr, hit_inc;
  logic [DataW-1:0] hit_new;

  logic                     issuing, take, is_match;
  logic [IdxW+RuleIdxW-1:0] ins_idx_ext, best_idx_ext;

  assign busy    = (state_q != S_IDLE);
  assign take    = start && !busy;
  assign issuing = (ptr_q != cnt_q);

  assign ins_idx_ext  = {{RuleIdxW{1'b0}}, cnt_q[IdxW-1:0]};
  assign best_idx_ext = {{RuleIdxW{1'b0}}, best_idx_q};

  assign rule_wdata = '{kind:      rule_kind_i,
                        threshold: rule_threshold_i,
                        act_kind:  new_action_kind_i,
                        act_value: new_action_value_i,
                        prio:      new_priority_i};

  // A rule beats the best so far only with a strictly larger priority, so
  // the earliest rule keeps a tie and a zero priority never wins.
  assign is_match = (rule_rdata.kind == kind_q) &&
                    (!decide_q || (rule_rdata.threshold <= obs_q)) &&
                    (rule_rdata.prio > best_pri_q);

  ppmt_rule_store #(
    .Depth (TABLE_DEPTH),
    .IdxW  (IdxW)
  ) u_rule_store (
    .clk_i   (clk_i),
    .we_i    (rule_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (rule_wdata),
    .re_i    (rule_re),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (rule_rdata)
  );

  ppmt_hit_store #(
    .Depth (TABLE_DEPTH),
    .IdxW  (IdxW)
  ) u_hit_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_en_i   (hit_clr),
    .clr_addr_i (cnt_q[IdxW-1:0]),
    .inc_en_i   (hit_inc),
    .inc_addr_i (best_idx_q),
    .hits_o     (hit_new)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rd_vld_d    = 1'b0;
    found_d     = found_q;
    valid_d     = 1'b0;
    decisions_d = decisions_q;
    applied_d   = applied_q;
    failed_d    = failed_q;
    decide_d    = decide_q;
    kind_d      = kind_q;
    obs_d       = obs_q;
    cur_d       = cur_q;
    rd_idx_d    = ptr_q[IdxW-1:0];
    best_pri_d  = best_pri_q;
    best_idx_d  = best_idx_q;
    best_ak_d   = best_ak_q;
    best_av_d   = best_av_q;
    status_d    = status_q;
    ridx_d      = ridx_q;
    ak_d        = ak_q;
    av_d        = av_q;
    rec_d       = rec_q;
    hits_d      = hits_q;
    rule_we     = 1'b0;
    rule_re     = 1'b0;
    hit_clr     = 1'b0;
    hit_inc     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (take) begin
          case (opcode_i)
            OP_INSERT: begin
              valid_d = 1'b1;
              ak_d    = '0;
              av_d    = '0;
              rec_d   = '0;
              hits_d  = '0;
              if (cnt_q == FullCnt) begin
                status_d = ST_FULL;
                ridx_d   = '0;
              end else begin
                rule_we  = 1'b1;
                hit_clr  = 1'b1;
                cnt_d    = cnt_q + 1'b1;
                status_d = ST_INSERTED;
                ridx_d   = ins_idx_ext[RuleIdxW-1:0];
              end
            end
            OP_DECIDE, OP_RECOMMEND: begin
              decide_d   = (opcode_i == OP_DECIDE);
              kind_d     = rule_kind_i;
              obs_d      = observed_value_i;
              cur_d      = current_setting_i;
              ptr_d      = '0;
              found_d    = 1'b0;
              best_pri_d = '0;
              state_d    = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; compare the registered read data in the cycle after.
        if (issuing) begin
          rule_re  = 1'b1;
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + 1'b1;
        end
        if (rd_vld_q && is_match) begin
          found_d    = 1'b1;
          best_pri_d = rule_rdata.prio;
          best_idx_d = rd_idx_q;
          best_ak_d  = rule_rdata.act_kind;
          best_av_d  = rule_rdata.act_value;
        end
        if (!issuing && !rd_vld_q) begin
          if (decide_q && found_q) begin
            hit_inc = 1'b1;
            state_d = S_HIT;
          end else begin
            valid_d = 1'b1;
            state_d = S_IDLE;
            hits_d  = '0;
            if (found_q && !decide_q) begin
              status_d = ST_APPLIED;
              ridx_d   = best_idx_ext[RuleIdxW-1:0];
              ak_d     = best_ak_q;
              av_d     = best_av_q;
              rec_d    = {{(WideW-DataW){1'b0}}, best_av_q};
            end else begin
              status_d = ST_NO_MATCH;
              ridx_d   = '0;
              ak_d     = '0;
              av_d     = '0;
              rec_d    = decide_q ? '0 : cur_q;
            end
          end
        end
      end

      S_HIT: begin
        valid_d     = 1'b1;
        state_d     = S_IDLE;
        decisions_d = decisions_q + 1'b1;
        if (action_ok(best_ak_q)) begin
          applied_d = applied_q + 1'b1;
          status_d  = ST_APPLIED;
        end else begin
          failed_d  = failed_q + 1'b1;
          status_d  = ST_BAD_ACTION;
        end
        ridx_d = best_idx_ext[RuleIdxW-1:0];
        ak_d   = best_ak_q;
        av_d   = best_av_q;
        rec_d  = '0;
        hits_d = hit_new;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      valid_q     <= 1'b0;
      decisions_q <= '0;
      applied_q   <= '0;
      failed_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      valid_q     <= valid_d;
      decisions_q <= decisions_d;
      applied_q   <= applied_d;
      failed_q    <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    decide_q   <= decide_d;
    kind_q     <= kind_d;
    obs_q      <= obs_d;
    cur_q      <= cur_d;
    rd_idx_q   <= rd_idx_d;
    best_pri_q <= best_pri_d;
    best_idx_q <= best_idx_d;
    best_ak_q  <= best_ak_d;
    best_av_q  <= best_av_d;
    status_q   <= status_d;
    ridx_q     <= ridx_d;
    ak_q       <= ak_d;
    av_q       <= av_d;
    rec_q      <= rec_d;
    hits_q     <= hits_d;
  end

  assign result_valid_o        = valid_q;
  assign status_o              = status_q;
  assign rule_index_o          = ridx_q;
  assign chosen_action_kind_o  = ak_q;
  assign chosen_action_value_o = av_q;
  assign recommendation_o      = rec_q;
  assign rule_hits_o           = hits_q;
  assign decisions_total_o     = decisions_q;
  assign applied_total_o       = applied_q;
  assign failed_total_o        = failed_q;

endmodule

>>> rtl/ppmt_rule_store.sv
`timescale 1ns / 1ps
// Rule memory: one write port, one registered read port.
module ppmt_rule_store import ppmt_pkg::*; #(
  parameter int unsigned Depth = TableDepthDefault,
  parameter int unsigned IdxW  = 10
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  rule_t           wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output rule_t           rdata_o
);

  rule_t mem_q [Depth];
  rule_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ppmt_hit_store.sv
`timescale 1ns / 1ps
// Hit count memory with a read, increment and write-back sequence.
module ppmt_hit_store import ppmt_pkg::*; #(
  parameter int unsigned Depth = TableDepthDefault,
  parameter int unsigned IdxW  = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_en_i,
  input  logic [IdxW-1:0]  clr_addr_i,
  input  logic             inc_en_i,
  input  logic [IdxW-1:0]  inc_addr_i,
  output logic [DataW-1:0] hits_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;
  logic             pend_q;
  logic [IdxW-1:0]  pend_addr_q;

  // The incremented count is written back the cycle after the read.
  assign hits_o = rdata_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= inc_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (inc_en_i) begin
      rdata_q     <= mem_q[inc_addr_i];
      pend_addr_q <= inc_addr_i;
    end
    if (pend_q) begin
      mem_q[pend_addr_q] <= hits_o;
    end else if (clr_en_i) begin
      mem_q[clr_addr_i] <= '0;
    end
  end

endmodule
